// ----- hw/rtl/dsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dsm_pkg;

   // operand length limit and derived sizes
   localparam int MAX_DIGITS = 32;
   localparam int RADIX      = 10;
   localparam int DIGIT_W    = 4;
   localparam int OPND_AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int PROD_DEPTH = 2 * MAX_DIGITS;
   localparam int PROD_AW    = $clog2(PROD_DEPTH);
   localparam int SUM_W      = 7;
   // reciprocal of ten, exact for sums far beyond the largest digit step
   localparam int RECIP_MUL  = 205;
   localparam int RECIP_SHR  = 11;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(RADIX - 1);

   typedef struct packed {
      logic [DIGIT_W-1:0] first_digit;
      logic [DIGIT_W-1:0] second_digit;
      logic               last_digit;
   } req_payload_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] product_digit;
      logic               final_digit;
      logic               zero_product;
   } rsp_payload_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] quot;
      logic [DIGIT_W-1:0] rem;
   } digit_split_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_ROW,
      S_MAC,
      S_TAIL,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_OUT_RD,
      S_OUT_WR,
      S_ZERO
   } state_type;

   // digits above nine saturate to nine
   function automatic logic [DIGIT_W-1:0] sat_digit(input logic [DIGIT_W-1:0] v);
      return (v > DIGIT_MAX) ? DIGIT_MAX : v;
   endfunction

   // split a step sum (at most 99) into carry and decimal digit
   function automatic digit_split_type split_decimal(input logic [SUM_W-1:0] sum);
      logic [SUM_W+8-1:0] scaled;
      logic [SUM_W-1:0]   back;
      digit_split_type    res;
      scaled   = (SUM_W + 8)'(sum) * (SUM_W + 8)'(RECIP_MUL);
      res.quot = scaled[RECIP_SHR +: DIGIT_W];
      back     = SUM_W'(res.quot) * SUM_W'(RADIX);
      res.rem  = DIGIT_W'(sum - back);
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/decimal_schoolbook_multiplier.sv -----
`timescale 1ns / 1ps
`default_nettype none
// decimal schoolbook multiplier
// request channel (req_valid / req_ready / req_payload) carries one digit pair per
// transaction, most significant pair first; last_digit marks the least significant pair
// and starts the multiply. pairs beyond the operand store capacity are dropped.
// response channel (rsp_valid / rsp_ready / rsp_payload) returns the product digits,
// most significant first, leading zeros stripped, final_digit on the last one; a zero
// product comes back as a single 0 with zero_product set.
// sequence for n loaded pairs: one pair is loaded per cycle, then n rows of
// multiply-accumulate run on the single digit mac unit (one step a cycle, plus a d1
// fetch and a carry write-back per row), then the scan skips leading zeros and each
// product digit is read and sent.
// req_ready is high only while loading; the block takes one operation at a time.
// the response sits in an output register, so the last digit can wait for the
// receiver while the next load already starts; a stalled receiver holds the sequencer
// before the next digit. synchronous reset empties the load count, clears the
// response valid flag and the product valid bits and returns to loading.
module decimal_schoolbook_multiplier
   import dsm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   // operand and product memories
   logic [DIGIT_W-1:0] first_mem  [MAX_DIGITS];
   logic [DIGIT_W-1:0] second_mem [MAX_DIGITS];
   logic [DIGIT_W-1:0] prod_mem   [PROD_DEPTH];

   // sequencer state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [OPND_AW-1:0] a_ff, a_in;
   logic [OPND_AW-1:0] b_ff, b_in;
   logic [PROD_AW-1:0] idx_ff, idx_in;
   logic [DIGIT_W-1:0] carry_ff, carry_in;
   logic [PROD_DEPTH-1:0] pvalid_ff, pvalid_in;

   // read data registers
   logic [DIGIT_W-1:0] first_rd_ff, second_rd_ff, prod_rd_ff;
   logic               prod_rv_ff;

   // response output register
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_data_ff;

   // memory controls
   logic               opnd_we;
   logic [OPND_AW-1:0] opnd_waddr;
   logic               first_re, second_re, prod_re, prod_we;
   logic [OPND_AW-1:0] first_raddr, second_raddr;
   logic [PROD_AW-1:0] prod_raddr, prod_waddr;
   logic [DIGIT_W-1:0] prod_wdata;
   logic               rsp_load;
   rsp_payload_type    rsp_load_data;

   // datapath
   logic               req_fire, slot_free, full;
   logic [CNT_W-1:0]   n_m1, first_idx, second_idx;
   logic [CNT_W:0]     scan_top;
   logic [DIGIT_W-1:0] prod_val;
   logic [2*DIGIT_W-1:0] digit_mul;
   logic [SUM_W-1:0]   step_sum;
   digit_split_type    step_split;
   logic               row_end, last_row;

   assign req_ready = (state_ff == S_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CNT_W'(MAX_DIGITS));

   assign n_m1       = n_ff - CNT_W'(1);
   assign first_idx  = n_m1 - CNT_W'(a_ff);
   // next column in a row reads one place further from the least significant end
   assign second_idx = (state_ff == S_ROW) ? n_m1 : (n_m1 - CNT_W'(b_ff) - CNT_W'(1));
   assign scan_top   = {n_ff, 1'b0} - (CNT_W + 1)'(1);

   // product digits never written in this operation read as zero
   assign prod_val   = prod_rv_ff ? prod_rd_ff : '0;
   assign digit_mul  = first_rd_ff * second_rd_ff;
   assign step_sum   = SUM_W'(digit_mul) + SUM_W'(prod_val) + SUM_W'(carry_ff);
   assign step_split = split_decimal(step_sum);
   assign row_end    = (CNT_W'(b_ff) == n_m1);
   assign last_row   = (CNT_W'(a_ff) == n_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         pvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pvalid_ff <= pvalid_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      idx_ff   <= idx_in;
      carry_ff <= carry_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_load_data;
      end
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (opnd_we) begin
         first_mem[opnd_waddr]  <= sat_digit(req_payload.first_digit);
         second_mem[opnd_waddr] <= sat_digit(req_payload.second_digit);
      end
      if (first_re) begin
         first_rd_ff <= first_mem[first_raddr];
      end
      if (second_re) begin
         second_rd_ff <= second_mem[second_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (prod_we) begin
         prod_mem[prod_waddr] <= prod_wdata;
      end
      if (prod_re) begin
         prod_rd_ff <= prod_mem[prod_raddr];
         prod_rv_ff <= pvalid_ff[prod_raddr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      idx_in        = idx_ff;
      carry_in      = carry_ff;
      pvalid_in     = pvalid_ff;
      opnd_we       = 1'b0;
      opnd_waddr    = count_ff[OPND_AW-1:0];
      first_re      = 1'b0;
      first_raddr   = first_idx[OPND_AW-1:0];
      second_re     = 1'b0;
      second_raddr  = second_idx[OPND_AW-1:0];
      prod_re       = 1'b0;
      prod_raddr    = idx_ff;
      prod_we       = 1'b0;
      prod_waddr    = PROD_AW'(a_ff) + PROD_AW'(b_ff);
      prod_wdata    = step_split.rem;
      rsp_load      = 1'b0;
      rsp_load_data = '{product_digit: prod_val,
                        final_digit:   (idx_ff == '0),
                        zero_product:  1'b0};

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               opnd_we  = !full;
               count_in = full ? count_ff : (count_ff + CNT_W'(1));
               if (req_payload.last_digit) begin
                  n_in      = count_in;
                  count_in  = '0;
                  a_in      = '0;
                  pvalid_in = '0;
                  state_in  = S_ROW;
               end
            end
         end
         // fetch the row digit, the first column digit and the product digit
         S_ROW: begin
            first_re   = 1'b1;
            second_re  = 1'b1;
            prod_re    = 1'b1;
            prod_raddr = PROD_AW'(a_ff);
            b_in       = '0;
            carry_in   = '0;
            state_in   = S_MAC;
         end
         // one digit multiply-accumulate per cycle, next column read in flight
         S_MAC: begin
            prod_we               = 1'b1;
            pvalid_in[prod_waddr] = 1'b1;
            carry_in              = step_split.quot;
            if (row_end) begin
               state_in = S_TAIL;
            end else begin
               second_re  = 1'b1;
               prod_re    = 1'b1;
               prod_raddr = PROD_AW'(a_ff) + PROD_AW'(b_ff) + PROD_AW'(1);
               b_in       = b_ff + OPND_AW'(1);
            end
         end
         // row carry lands one place above the row, always a fresh position
         S_TAIL: begin
            prod_we               = 1'b1;
            prod_waddr            = PROD_AW'(a_ff) + PROD_AW'(n_ff);
            prod_wdata            = carry_ff;
            pvalid_in[prod_waddr] = 1'b1;
            if (last_row) begin
               idx_in   = scan_top[PROD_AW-1:0];
               state_in = S_SCAN_RD;
            end else begin
               a_in     = a_ff + OPND_AW'(1);
               state_in = S_ROW;
            end
         end
         S_SCAN_RD: begin
            prod_re  = 1'b1;
            state_in = S_SCAN_CHK;
         end
         // strip leading zeros; the digit found is already in the read register
         S_SCAN_CHK: begin
            if (prod_val != '0) begin
               state_in = S_OUT_WR;
            end else if (idx_ff == '0) begin
               state_in = S_ZERO;
            end else begin
               idx_in   = idx_ff - PROD_AW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_OUT_RD: begin
            prod_re  = 1'b1;
            state_in = S_OUT_WR;
         end
         S_OUT_WR: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (idx_ff == '0) begin
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff - PROD_AW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         S_ZERO: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_load_data = '{product_digit: '0, final_digit: 1'b1, zero_product: 1'b1};
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // a last pair always leaves the load count empty
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.last_digit |=> count_ff == '0)
      else $error("load count not cleared after last pair");

   // the column counter stays inside the operand length
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MAC |-> CNT_W'(b_ff) < n_ff)
      else $error("column index beyond operand length");

   // a zero product is a single flagged zero digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.zero_product |->
         rsp_payload.final_digit && rsp_payload.product_digit == '0)
      else $error("malformed zero product");

   // every emitted digit is decimal
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.product_digit <= DIGIT_MAX)
      else $error("product digit above nine");

endmodule

`default_nettype wire
